@@ sv/pssm_pkg.sv @@
// ----------------------------------------------------------------------------
// pssm_pkg: shared types and codes for the packet slot status manager
// Word layouts, operation codes, slot status codes and outcome codes.
// ----------------------------------------------------------------------------
package pssm_pkg;

    // Number of packet buffer slots. The slot index fields are three bits wide,
    // so the slot count stays at or below eight.
    localparam int SLOT_COUNT  = 8;
    localparam int SLOT_IDX_W  = 3;
    localparam int OPCODE_W    = 3;
    localparam int OUTCOME_W   = 2;
    localparam int STATUS_W    = 2;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_ALLOCATE        = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_FREE            = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_MARK_RECEIVED   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_GET_RECEIVED    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_MARK_PROCESSING = 3'd4;

    // Slot status codes
    localparam logic [STATUS_W-1:0] ST_FREE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RECEIVED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PROCESSING = 2'd3;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_OK    = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_NONE  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_WRONG = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [SLOT_IDX_W-1:0] slot_index;
    } in_word_t;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] result_slot;
        logic [OUTCOME_W-1:0]  outcome;
    } out_word_t;

endpackage

@@ sv/packet_slot_status_manager_core.sv @@
// ----------------------------------------------------------------------------
// packet_slot_status_manager_core: first-fit slot allocator with status
// Tracks a two-bit status per packet buffer slot and serves one operation
// per input word, answering with a slot index and an outcome.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid / s_ready / s_data) carries one operation word:
//   opcode and the addressed slot. Result channel (m_valid / m_ready /
//   m_data) returns exactly one word per operation: result slot and outcome.
//   Each word passes through the input register, then the result register.
//   Throughput: one word per cycle while the receiver takes results. The
//   lowest-slot search and the status update for a word are done
//   combinationally between the input register and the result register,
//   so each word sees the slot state left by the word before it.
//   Reset (aresetn low, synchronous) marks every slot free and empties both
//   pipeline registers.
//   When the receiver stalls, the result register holds its word; the input
//   register still takes one more word, after which s_ready drops until the
//   result is taken. No word is lost or repeated.
// ----------------------------------------------------------------------------
module packet_slot_status_manager_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pssm_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pssm_pkg::out_word_t  m_data
);
    import pssm_pkg::*;

    // Pipeline registers
    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;

    // Slot status table
    logic [STATUS_W-1:0] status_reg  [SLOT_COUNT];
    logic [STATUS_W-1:0] status_next [SLOT_COUNT];

    logic      advance;
    out_word_t result;

    // Lowest-slot search results
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_slot;
    logic                  recv_found;
    logic [SLOT_IDX_W-1:0] recv_slot;

    logic                  idx_valid;
    logic [STATUS_W-1:0]   cur_status;

    // Advance the word in the input register whenever the result register is
    // empty or is being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    // Priority search: scan from the top down so the lowest match wins.
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        recv_found = 1'b0;
        recv_slot  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (status_reg[i] == ST_FREE) begin
                free_found = 1'b1;
                free_slot  = SLOT_IDX_W'(i);
            end
            if (status_reg[i] == ST_RECEIVED) begin
                recv_found = 1'b1;
                recv_slot  = SLOT_IDX_W'(i);
            end
        end
    end

    // Addressed slot lookup; an index past the table reads as free.
    always_comb begin
        idx_valid  = {1'b0, in_word_reg.slot_index} < (SLOT_IDX_W + 1)'(SLOT_COUNT);
        cur_status = ST_FREE;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (in_word_reg.slot_index == SLOT_IDX_W'(i)) begin
                cur_status = status_reg[i];
            end
        end
    end

    // Operation decode and status update.
    always_comb begin
        logic                  wr_en;
        logic [SLOT_IDX_W-1:0] wr_slot;
        logic [STATUS_W-1:0]   wr_status;

        wr_en              = 1'b0;
        wr_slot            = in_word_reg.slot_index;
        wr_status          = ST_FREE;
        result.result_slot = in_word_reg.slot_index;
        result.outcome     = OUT_WRONG;

        unique case (in_word_reg.opcode)
            OP_ALLOCATE: begin
                if (free_found) begin
                    wr_en              = 1'b1;
                    wr_slot            = free_slot;
                    wr_status          = ST_ALLOCATED;
                    result.result_slot = free_slot;
                    result.outcome     = OUT_OK;
                end else begin
                    result.result_slot = '0;
                    result.outcome     = OUT_NONE;
                end
            end
            OP_FREE: begin
                if (idx_valid && cur_status != ST_FREE) begin
                    wr_en          = 1'b1;
                    wr_status      = ST_FREE;
                    result.outcome = OUT_OK;
                end
            end
            OP_MARK_RECEIVED: begin
                if (idx_valid && cur_status == ST_ALLOCATED) begin
                    wr_en          = 1'b1;
                    wr_status      = ST_RECEIVED;
                    result.outcome = OUT_OK;
                end
            end
            OP_GET_RECEIVED: begin
                result.result_slot = recv_found ? recv_slot : '0;
                result.outcome     = recv_found ? OUT_OK : OUT_NONE;
            end
            OP_MARK_PROCESSING: begin
                if (idx_valid && (cur_status == ST_RECEIVED ||
                                  cur_status == ST_ALLOCATED)) begin
                    wr_en          = 1'b1;
                    wr_status      = ST_PROCESSING;
                    result.outcome = OUT_OK;
                end
            end
            default: begin
                // Unused opcode: no change, report wrong state.
            end
        endcase

        for (int i = 0; i < SLOT_COUNT; i++) begin
            status_next[i] = status_reg[i];
            if (advance && wr_en && wr_slot == SLOT_IDX_W'(i)) begin
                status_next[i] = wr_status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                status_reg[i] <= ST_FREE;
            end
        end else begin
            // Capture a new word whenever the input register frees up.
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            // Load the result on advance; drop it once taken.
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            status_reg <= status_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
        if (advance) begin
            out_word_reg <= result;
        end
    end

endmodule
